@@ hw/rtl/matrix3_inverse_top_defines.svh @@
// Assertion macros for the 3x3 matrix inverse RTL.
// Included by modules that carry concurrent checks; expects clk_i and rst_ni in scope.
`ifndef MATRIX3_INVERSE_TOP_DEFINES_SVH
`define MATRIX3_INVERSE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define M3I_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define M3I_ASSERT_IMP(lbl, ante, cons, msg) \
  `M3I_ASSERT(lbl, (ante) |-> (cons), msg)
`else
`define M3I_ASSERT(lbl, prop, msg)
`define M3I_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

@@ hw/rtl/m3i_pkg.sv @@
// Shared widths and word types for the 3x3 matrix inverse pipeline.
// No dependencies; used by the interfaces and every module of the block.
`timescale 1ns / 1ps
package m3i_pkg;
  localparam int ELEM_W  = 32;
  localparam int FRAC_W  = 16;
  localparam int NELEM   = 9;
  localparam int ROW_N   = 3;
  localparam int PROD_W  = 2 * ELEM_W;
  localparam int COF_W   = PROD_W + 1;
  localparam int MAG_W   = PROD_W;
  localparam int DET_W   = ELEM_W + COF_W + 1;
  localparam int DMAG_W  = DET_W - 1;
  localparam int QBITS   = ELEM_W + 1;
  localparam int SHIFT_W = 2 * FRAC_W;
  localparam int LOW_W   = QBITS - SHIFT_W;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [COF_W-1:0]  cof_t;

  typedef struct packed {
    logic [NELEM-1:0][COF_W-1:0]  cof;
    logic [ROW_N-1:0][ELEM_W-1:0] row0;
  } cof_word_t;

  typedef struct packed {
    logic [DMAG_W-1:0]           det_mag;
    logic                        det_neg;
    logic                        det_zero;
    logic [NELEM-1:0][MAG_W-1:0] cof_mag;
    logic [NELEM-1:0]            cof_neg;
  } quo_word_t;

  typedef struct packed {
    logic [NELEM-1:0][ELEM_W-1:0] b;
    logic                         singular;
    logic                         clipped;
  } inv_word_t;
endpackage

@@ hw/rtl/m3i_if.sv @@
// Valid/ready stream interfaces for the matrix inverse ports.
// Depends on m3i_pkg for the element type.
`timescale 1ns / 1ps
interface m3i_in_if;
  logic valid;
  logic ready;
  m3i_pkg::elem_t a00, a01, a02, a10, a11, a12, a20, a21, a22;
  modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, input ready);
  modport sink (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, output ready);
endinterface

interface m3i_out_if;
  logic valid;
  logic ready;
  m3i_pkg::elem_t b00, b01, b02, b10, b11, b12, b20, b21, b22;
  logic singular;
  logic clipped;
  modport source (output valid, b00, b01, b02, b10, b11, b12, b20, b21, b22, singular,
                  clipped, input ready);
  modport sink (input valid, b00, b01, b02, b10, b11, b12, b20, b21, b22, singular,
                clipped, output ready);
endinterface

@@ hw/rtl/m3i_cofactor.sv @@
// Cofactor stages: eighteen element products, then the nine 2x2 minors.
// Depends on m3i_pkg.
`timescale 1ns / 1ps
module m3i_cofactor (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             valid_i,
  output logic                                             ready_o,
  input  logic [m3i_pkg::NELEM-1:0][m3i_pkg::ELEM_W-1:0]   a_i,
  output logic                                             valid_o,
  input  logic                                             ready_i,
  output m3i_pkg::cof_word_t                               word_o
);
  localparam int NSTG  = 2;
  localparam int NPROD = 2 * m3i_pkg::NELEM;
  // Left and right factors of each product; minor i is product 2i minus product 2i+1.
  localparam int MUL_L [NPROD] = '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
  localparam int MUL_R [NPROD] = '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};

  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] vld_d;
  logic [NSTG:0]   adv;
  logic signed [m3i_pkg::PROD_W-1:0] prod_q [NPROD];
  logic [m3i_pkg::ROW_N-1:0][m3i_pkg::ELEM_W-1:0] row0_q;
  m3i_pkg::cof_word_t word_q;

  always_comb begin
    adv[NSTG] = ready_i;
    for (int k = NSTG - 1; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign vld_d = {vld_q[NSTG-2:0], valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_d[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      for (int j = 0; j < NPROD; j++) begin
        prod_q[j] <= $signed(a_i[MUL_L[j]]) * $signed(a_i[MUL_R[j]]);
      end
      row0_q <= a_i[m3i_pkg::ROW_N-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      for (int i = 0; i < m3i_pkg::NELEM; i++) begin
        word_q.cof[i] <= m3i_pkg::COF_W'(prod_q[2*i]) - m3i_pkg::COF_W'(prod_q[2*i+1]);
      end
      word_q.row0 <= row0_q;
    end
  end

  assign ready_o = adv[0];
  assign valid_o = vld_q[NSTG-1];
  assign word_o  = word_q;
endmodule

@@ hw/rtl/m3i_det.sv @@
// Determinant stages: split first-row expansion, term sums, then magnitudes and signs.
// Depends on m3i_pkg.
`timescale 1ns / 1ps
module m3i_det (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  m3i_pkg::cof_word_t  word_i,
  output logic                valid_o,
  input  logic                ready_i,
  output m3i_pkg::quo_word_t  word_o
);
  localparam int NSTG = 4;

  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] vld_d;
  logic [NSTG:0]   adv;
  m3i_pkg::cof_t lo_q [m3i_pkg::ROW_N];
  m3i_pkg::cof_t hi_q [m3i_pkg::ROW_N];
  logic signed [m3i_pkg::DET_W-1:0] term_q [m3i_pkg::ROW_N];
  logic signed [m3i_pkg::DET_W-1:0] det_q;
  logic [m3i_pkg::NELEM-1:0][m3i_pkg::COF_W-1:0] cof_q [NSTG-1];
  logic [m3i_pkg::DET_W-1:0] det_abs;
  logic [m3i_pkg::COF_W-1:0] cof_abs [m3i_pkg::NELEM];
  m3i_pkg::quo_word_t word_q;

  always_comb begin
    adv[NSTG] = ready_i;
    for (int k = NSTG - 1; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign vld_d = {vld_q[NSTG-2:0], valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_d[k];
        end
      end
    end
  end

  // Each first-row term a0k * c(3k) is split at bit 32 of the cofactor.
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      for (int k = 0; k < m3i_pkg::ROW_N; k++) begin
        lo_q[k] <= $signed(word_i.row0[k])
                   * $signed({1'b0, word_i.cof[m3i_pkg::ROW_N*k][m3i_pkg::ELEM_W-1:0]});
        hi_q[k] <= $signed(word_i.row0[k])
                   * $signed(word_i.cof[m3i_pkg::ROW_N*k][m3i_pkg::COF_W-1:m3i_pkg::ELEM_W]);
      end
      cof_q[0] <= word_i.cof;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      for (int k = 0; k < m3i_pkg::ROW_N; k++) begin
        term_q[k] <= (m3i_pkg::DET_W'(hi_q[k]) <<< m3i_pkg::ELEM_W) + m3i_pkg::DET_W'(lo_q[k]);
      end
      cof_q[1] <= cof_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      det_q    <= term_q[0] + term_q[1] + term_q[2];
      cof_q[2] <= cof_q[1];
    end
  end

  always_comb begin
    det_abs = det_q[m3i_pkg::DET_W-1] ? -det_q : det_q;
    for (int i = 0; i < m3i_pkg::NELEM; i++) begin
      cof_abs[i] = cof_q[2][i][m3i_pkg::COF_W-1] ? -$signed(cof_q[2][i]) : cof_q[2][i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      word_q.det_mag  <= det_abs[m3i_pkg::DMAG_W-1:0];
      word_q.det_neg  <= det_q[m3i_pkg::DET_W-1];
      word_q.det_zero <= (det_q == '0);
      for (int i = 0; i < m3i_pkg::NELEM; i++) begin
        word_q.cof_mag[i] <= cof_abs[i][m3i_pkg::MAG_W-1:0];
        word_q.cof_neg[i] <= cof_q[2][i][m3i_pkg::COF_W-1];
      end
    end
  end

  assign ready_o = adv[0];
  assign valid_o = vld_q[NSTG-1];
  assign word_o  = word_q;
endmodule

@@ hw/rtl/m3i_divider.sv @@
// Nine-lane pipelined restoring divider, one quotient bit per stage, then saturation.
// Depends on m3i_pkg and the assertion macros in matrix3_inverse_top_defines.svh.
`timescale 1ns / 1ps
`include "matrix3_inverse_top_defines.svh"
module m3i_divider (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  m3i_pkg::quo_word_t  word_i,
  output logic                valid_o,
  input  logic                ready_i,
  output m3i_pkg::inv_word_t  word_o
);
  localparam int QB   = m3i_pkg::QBITS;
  localparam int NSTG = QB + 2;
  localparam int SAT  = NSTG - 1;
  localparam logic [QB-1:0] LIM_NEG = {{(QB - m3i_pkg::ELEM_W){1'b0}}, 1'b1,
                                       {(m3i_pkg::ELEM_W - 1){1'b0}}};
  localparam logic [QB-1:0] LIM_POS = LIM_NEG - 1'b1;

  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] vld_d;
  logic [NSTG:0]   adv;
  logic [m3i_pkg::DMAG_W-1:0] rem_q [QB+1][m3i_pkg::NELEM];
  logic [QB-1:0]              quo_q [QB+1][m3i_pkg::NELEM];
  logic [m3i_pkg::LOW_W-1:0]  low_q [QB+1][m3i_pkg::NELEM];
  logic [m3i_pkg::NELEM-1:0]  big_q [QB+1];
  logic [m3i_pkg::NELEM-1:0]  neg_q [QB+1];
  logic [m3i_pkg::DMAG_W-1:0] div_q [QB+1];
  logic                       zero_q [QB+1];
  logic [QB-1:0]              sat_mag [m3i_pkg::NELEM];
  logic [QB-1:0]              sgn_mag [m3i_pkg::NELEM];
  logic [m3i_pkg::NELEM-1:0]  over;
  m3i_pkg::inv_word_t         word_q;

  always_comb begin
    adv[NSTG] = ready_i;
    for (int k = NSTG - 1; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign vld_d = {vld_q[NSTG-2:0], valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_d[k];
        end
      end
    end
  end

  // The dividend is the cofactor magnitude shifted up by the doubled fraction width. Its
  // top part seeds the remainder; a quotient that does not fit in QB bits is flagged as too big.
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      div_q[0]  <= word_i.det_mag;
      zero_q[0] <= word_i.det_zero;
      for (int i = 0; i < m3i_pkg::NELEM; i++) begin
        big_q[0][i] <= m3i_pkg::DMAG_W'(word_i.cof_mag[i][m3i_pkg::MAG_W-1:m3i_pkg::LOW_W])
                       >= word_i.det_mag;
        rem_q[0][i] <= m3i_pkg::DMAG_W'(word_i.cof_mag[i][m3i_pkg::MAG_W-1:m3i_pkg::LOW_W]);
        low_q[0][i] <= word_i.cof_mag[i][m3i_pkg::LOW_W-1:0];
        neg_q[0][i] <= word_i.cof_neg[i] ^ word_i.det_neg;
        quo_q[0][i] <= '0;
      end
    end
  end

  for (genvar s = 1; s <= QB; s++) begin : g_step
    logic [m3i_pkg::DMAG_W:0] trial [m3i_pkg::NELEM];
    logic [m3i_pkg::DMAG_W:0] diff  [m3i_pkg::NELEM];
    logic [m3i_pkg::NELEM-1:0] take;

    always_comb begin
      for (int i = 0; i < m3i_pkg::NELEM; i++) begin
        trial[i] = {rem_q[s-1][i], low_q[s-1][i][m3i_pkg::LOW_W-1]};
        diff[i]  = trial[i] - {1'b0, div_q[s-1]};
        take[i]  = trial[i] >= {1'b0, div_q[s-1]};
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[s]) begin
        for (int i = 0; i < m3i_pkg::NELEM; i++) begin
          rem_q[s][i] <= take[i] ? diff[i][m3i_pkg::DMAG_W-1:0]
                                 : trial[i][m3i_pkg::DMAG_W-1:0];
          quo_q[s][i] <= {quo_q[s-1][i][QB-2:0], take[i]};
          low_q[s][i] <= low_q[s-1][i] << 1;
        end
        big_q[s]  <= big_q[s-1];
        neg_q[s]  <= neg_q[s-1];
        div_q[s]  <= div_q[s-1];
        zero_q[s] <= zero_q[s-1];
      end
    end
  end

  // Saturate to the signed element range and apply the sign.
  always_comb begin
    for (int i = 0; i < m3i_pkg::NELEM; i++) begin
      if (zero_q[QB]) begin
        over[i]    = 1'b0;
        sat_mag[i] = '0;
      end else if (neg_q[QB][i]) begin
        over[i]    = big_q[QB][i] || (quo_q[QB][i] > LIM_NEG);
        sat_mag[i] = over[i] ? LIM_NEG : quo_q[QB][i];
      end else begin
        over[i]    = big_q[QB][i] || (quo_q[QB][i] > LIM_POS);
        sat_mag[i] = over[i] ? LIM_POS : quo_q[QB][i];
      end
      sgn_mag[i] = neg_q[QB][i] ? (~sat_mag[i] + 1'b1) : sat_mag[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[SAT]) begin
      for (int i = 0; i < m3i_pkg::NELEM; i++) begin
        word_q.b[i] <= sgn_mag[i][m3i_pkg::ELEM_W-1:0];
      end
      word_q.singular <= zero_q[QB];
      word_q.clipped  <= |over;
    end
  end

  assign ready_o = adv[0];
  assign valid_o = vld_q[SAT];
  assign word_o  = word_q;

  `M3I_ASSERT_IMP(a_sing_zero, valid_o && word_o.singular, word_o.b == '0, "singular word has nonzero elements")
  `M3I_ASSERT_IMP(a_sing_noclip, valid_o && word_o.singular, !word_o.clipped, "singular word flagged as clipped")
  `M3I_ASSERT_IMP(a_rem_bound, vld_q[QB] && !big_q[QB][0] && !zero_q[QB], rem_q[QB][0] < div_q[QB], "final remainder not below divisor")
endmodule

@@ hw/rtl/matrix3_inverse_top.sv @@
// 3x3 matrix inverse by adjugate, Q16.16 in and out, fully pipelined.
// Throughput: one word per cycle while out_o.ready is high; the 33 quotient bits each take a divider stage.
// Reset (rst_ni, asynchronous, active low) clears only the stage valid bits; the
// data registers are left as they are. Depends on m3i_pkg, m3i_if and the submodules.
`timescale 1ns / 1ps
module matrix3_inverse_top (
  input logic        clk_i,
  input logic        rst_ni,
  m3i_in_if.sink     in_i,
  m3i_out_if.source  out_o
);
  // Pipeline overview:
  //   m3i_cofactor : 2 stages, the eighteen 32x32 products and then the nine minors.
  //   m3i_det      : 4 stages, the first-row expansion with each 65-bit cofactor split
  //                  into 32- and 33-bit parts, term and determinant sums, and magnitudes.
  //   m3i_divider  : 35 stages, a range check, one restoring step per quotient bit, and a
  //                  saturation stage whose register is the output register.
  // Every stage has its own valid bit and loads whenever it is empty or the stage after it
  // moves, so bubbles are squeezed out and the input keeps accepting while a finished word
  // waits at the output, as long as some stage is still empty.

  logic [m3i_pkg::NELEM-1:0][m3i_pkg::ELEM_W-1:0] a_pack;
  logic               cof_valid;
  logic               cof_ready;
  m3i_pkg::cof_word_t cof_word;
  logic               quo_valid;
  logic               quo_ready;
  m3i_pkg::quo_word_t quo_word;
  m3i_pkg::inv_word_t inv_word;

  // Row-major packing of the input matrix.
  assign a_pack[0] = in_i.a00;
  assign a_pack[1] = in_i.a01;
  assign a_pack[2] = in_i.a02;
  assign a_pack[3] = in_i.a10;
  assign a_pack[4] = in_i.a11;
  assign a_pack[5] = in_i.a12;
  assign a_pack[6] = in_i.a20;
  assign a_pack[7] = in_i.a21;
  assign a_pack[8] = in_i.a22;

  m3i_cofactor u_cofactor (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .a_i     (a_pack),
    .valid_o (cof_valid),
    .ready_i (cof_ready),
    .word_o  (cof_word)
  );

  m3i_det u_det (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cof_valid),
    .ready_o (cof_ready),
    .word_i  (cof_word),
    .valid_o (quo_valid),
    .ready_i (quo_ready),
    .word_o  (quo_word)
  );

  m3i_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (quo_valid),
    .ready_o (quo_ready),
    .word_i  (quo_word),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .word_o  (inv_word)
  );

  // A zero determinant gives an all-zero inverse with the singular flag set.
  assign out_o.b00      = inv_word.b[0];
  assign out_o.b01      = inv_word.b[1];
  assign out_o.b02      = inv_word.b[2];
  assign out_o.b10      = inv_word.b[3];
  assign out_o.b11      = inv_word.b[4];
  assign out_o.b12      = inv_word.b[5];
  assign out_o.b20      = inv_word.b[6];
  assign out_o.b21      = inv_word.b[7];
  assign out_o.b22      = inv_word.b[8];
  assign out_o.singular = inv_word.singular;
  assign out_o.clipped  = inv_word.clipped;
endmodule
